// ----- src/dsp_pkg.sv -----
// ============================================================================
// dsp_pkg
// Shared types and constants for the DAG shortest path engine.
// ============================================================================
`default_nettype none

package dsp_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 4096;

   localparam int VTX_W    = 6;    // vertex field width on the ports
   localparam int CNT_W    = 7;    // vertex count register width
   localparam int WEIGHT_W = 17;   // edge weight width
   localparam int DIST_W   = 24;   // distance width

   localparam logic [CNT_W-1:0]  VCOUNT_RESET = 7'd64;
   localparam logic [DIST_W-1:0] DIST_INF     = {DIST_W{1'b1}};

   // Sequencer states
   typedef enum logic [3:0] {
      ST_LOAD,    // taking edges
      ST_CLR,     // clear in-degree and distance stores
      ST_DEG,     // count in-degrees
      ST_SEED,    // queue vertices with no incoming edges
      ST_KHEAD,   // pop next vertex of the topological walk
      ST_KSCAN,   // decrement in-degrees of its successors
      ST_RHEAD,   // pick next vertex in topological order
      ST_RSCAN,   // relax its out-edges
      ST_EMIT     // stream out one distance per vertex
   } state_type;

   typedef logic [1:0] phase_type;

   localparam phase_type PH_ADDR = 2'd0;
   localparam phase_type PH_DATA = 2'd1;
   localparam phase_type PH_WB   = 2'd2;

endpackage

`default_nettype wire

// ----- src/dsp_ram.sv -----
// ============================================================================
// dsp_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output.
// ============================================================================
`default_nettype none

module dsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/dag_shortest_path.sv -----
// ============================================================================
// dag_shortest_path
// Single-source shortest paths over a weighted DAG, source vertex 0.
// ============================================================================
// Usage:
//   Edges are issued one beat per cycle on the req_ channel: a beat is taken
//   at a clock edge with start high and busy low. While loading, busy stays
//   low, so in-range edges go into the edge RAM at one per cycle while it
//   has room. The beat with req_last_edge set starts the solve; busy then
//   stays high until the last distance has been sent. The solve runs from
//   RAMs: clear of the vertex stores, in-degree count over all edges,
//   seeding, topological walk (a scan of every edge per queued vertex),
//   relaxation (a scan of every edge per reachable queued vertex) and
//   output. Edge scans dominate the run time.
//   Results come out on rsp_ one per vertex, each valid for one cycle
//   with rsp_valid high; the receiver cannot stall them.
//   csr_vertex_count is written through csr_valid/csr_ready while idle.
//   Reset clears the edge count, the drop flag and sets vertex count to 64;
//   vertex stores are cleared by the solve itself at each job start.
// ============================================================================
`default_nettype none

module dag_shortest_path #(
   parameter int MAX_VERTICES = dsp_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = dsp_pkg::MAX_EDGES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // edge input
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [dsp_pkg::VTX_W-1:0]     req_edge_from,
   input  wire logic [dsp_pkg::VTX_W-1:0]     req_edge_to,
   input  wire logic [dsp_pkg::WEIGHT_W-1:0]  req_edge_weight,
   input  wire logic                          req_last_edge,
   // results
   output logic                               rsp_valid,
   output logic [dsp_pkg::VTX_W-1:0]          rsp_vertex_index,
   output logic signed [dsp_pkg::DIST_W-1:0]  rsp_distance,
   output logic                               rsp_last_result,
   output logic                               rsp_input_dropped,
   // configuration
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [dsp_pkg::CNT_W-1:0]     csr_vertex_count
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_VERTICES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int DW  = dsp_pkg::DIST_W;
   localparam int WW  = dsp_pkg::WEIGHT_W;
   localparam int EDW = 2 * VW + WW;
   localparam int IDW = EW;   // in-degree width

   localparam logic [dsp_pkg::CNT_W-1:0] MAXV_C = dsp_pkg::CNT_W'(MAX_VERTICES);
   localparam logic [EW-1:0]             MAXE_C = EW'(MAX_EDGES);
   localparam logic [CW-1:0]             MAXV_Q = CW'(MAX_VERTICES);

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   dsp_pkg::state_type state_ff, state_in;
   dsp_pkg::phase_type ph_ff, ph_in;

   logic [dsp_pkg::CNT_W-1:0] vcount_ff;
   logic [EW-1:0]             total_ff;
   logic                      drop_ff;
   logic [EW-1:0]             k_ff;
   logic [CW-1:0]             i_ff;
   logic [CW-1:0]             head_ff;
   logic [CW-1:0]             tail_ff;
   logic [VW-1:0]             node_ff;
   logic [VW-1:0]             v_ff;
   logic [DW-1:0]             d_ff;
   logic [DW-1:0]             nd_ff;

   logic                      rsp_valid_ff;
   logic [dsp_pkg::VTX_W-1:0] rsp_index_ff;
   logic [DW-1:0]             rsp_dist_ff;
   logic                      rsp_last_ff;
   logic                      rsp_drop_ff;

   // ------------------------------------------------------------------------
   // memory ports
   // ------------------------------------------------------------------------
   logic            edge_we;
   logic [EAW-1:0]  edge_waddr;
   logic [EDW-1:0]  edge_wdata;
   logic [EDW-1:0]  edge_rd;

   logic            deg_we;
   logic [VW-1:0]   deg_waddr;
   logic [IDW-1:0]  deg_wdata;
   logic [VW-1:0]   deg_raddr;
   logic [IDW-1:0]  deg_rd;

   logic            q_we;
   logic [VW-1:0]   q_waddr;
   logic [VW-1:0]   q_wdata;
   logic [VW-1:0]   q_rd;

   logic            dist_we;
   logic [VW-1:0]   dist_waddr;
   logic [DW-1:0]   dist_wdata;
   logic [VW-1:0]   dist_raddr;
   logic [DW-1:0]   dist_rd;

   // ------------------------------------------------------------------------
   // decode
   // ------------------------------------------------------------------------
   logic                      accept;
   logic [dsp_pkg::CNT_W-1:0] n_eff;
   logic [CW-1:0]             n_cnt;
   logic                      edge_ok;
   logic [VW-1:0]             e_from;
   logic [VW-1:0]             e_to;
   logic [WW-1:0]             e_wt;
   logic                      i_last;
   logic                      k_last;
   logic                      e_match;
   logic [IDW-1:0]            deg_dec;
   logic                      push_ok;

   assign accept = start && !busy;

   // effective vertex count, clamped to 1..MAX_VERTICES
   always_comb begin
      priority if (vcount_ff == '0) begin
         n_eff = dsp_pkg::CNT_W'(1);
      end else if (vcount_ff > MAXV_C) begin
         n_eff = MAXV_C;
      end else begin
         n_eff = vcount_ff;
      end
   end
   assign n_cnt = n_eff[CW-1:0];

   assign edge_ok = ({1'b0, req_edge_from} < n_eff) && ({1'b0, req_edge_to} < n_eff)
                    && (total_ff != MAXE_C);

   assign e_from  = edge_rd[EDW-1 -: VW];
   assign e_to    = edge_rd[WW +: VW];
   assign e_wt    = edge_rd[WW-1:0];
   assign e_match = (e_from == node_ff);

   assign i_last  = (CW'(i_ff + 1'b1) == n_cnt);
   assign k_last  = (EW'(k_ff + 1'b1) == total_ff);
   assign deg_dec = IDW'(deg_rd - 1'b1);
   assign push_ok = (deg_dec == '0) && (tail_ff < MAXV_Q);

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      unique case (state_ff)
         dsp_pkg::ST_LOAD: begin
            if (accept && req_last_edge) begin
               state_in = dsp_pkg::ST_CLR;
               ph_in    = dsp_pkg::PH_ADDR;
            end
         end
         dsp_pkg::ST_CLR: begin
            if (i_last) begin
               state_in = (total_ff == '0) ? dsp_pkg::ST_SEED : dsp_pkg::ST_DEG;
               ph_in    = dsp_pkg::PH_ADDR;
            end
         end
         dsp_pkg::ST_DEG: begin
            unique case (ph_ff)
               dsp_pkg::PH_ADDR: ph_in = dsp_pkg::PH_DATA;
               dsp_pkg::PH_DATA: ph_in = dsp_pkg::PH_WB;
               default: begin
                  ph_in = dsp_pkg::PH_ADDR;
                  if (k_last) begin
                     state_in = dsp_pkg::ST_SEED;
                  end
               end
            endcase
         end
         dsp_pkg::ST_SEED: begin
            if (ph_ff == dsp_pkg::PH_ADDR) begin
               ph_in = dsp_pkg::PH_DATA;
            end else begin
               ph_in = dsp_pkg::PH_ADDR;
               if (i_last) begin
                  state_in = dsp_pkg::ST_KHEAD;
               end
            end
         end
         dsp_pkg::ST_KHEAD: begin
            if (ph_ff == dsp_pkg::PH_ADDR) begin
               if (head_ff == tail_ff) begin
                  state_in = dsp_pkg::ST_RHEAD;
               end else begin
                  ph_in = dsp_pkg::PH_DATA;
               end
            end else begin
               ph_in = dsp_pkg::PH_ADDR;
               if (total_ff != '0) begin
                  state_in = dsp_pkg::ST_KSCAN;
               end
            end
         end
         dsp_pkg::ST_KSCAN, dsp_pkg::ST_RSCAN: begin
            unique case (ph_ff)
               dsp_pkg::PH_ADDR: ph_in = dsp_pkg::PH_DATA;
               dsp_pkg::PH_DATA: begin
                  if (e_match) begin
                     ph_in = dsp_pkg::PH_WB;
                  end else begin
                     ph_in = dsp_pkg::PH_ADDR;
                     if (k_last) begin
                        state_in = (state_ff == dsp_pkg::ST_KSCAN) ?
                                   dsp_pkg::ST_KHEAD : dsp_pkg::ST_RHEAD;
                     end
                  end
               end
               default: begin
                  ph_in = dsp_pkg::PH_ADDR;
                  if (k_last) begin
                     state_in = (state_ff == dsp_pkg::ST_KSCAN) ?
                                dsp_pkg::ST_KHEAD : dsp_pkg::ST_RHEAD;
                  end
               end
            endcase
         end
         dsp_pkg::ST_RHEAD: begin
            unique case (ph_ff)
               dsp_pkg::PH_ADDR: begin
                  if (head_ff == tail_ff) begin
                     state_in = dsp_pkg::ST_EMIT;
                  end else begin
                     ph_in = dsp_pkg::PH_DATA;
                  end
               end
               dsp_pkg::PH_DATA: ph_in = dsp_pkg::PH_WB;
               default: begin
                  ph_in = dsp_pkg::PH_ADDR;
                  if (dist_rd != dsp_pkg::DIST_INF && total_ff != '0) begin
                     state_in = dsp_pkg::ST_RSCAN;
                  end
               end
            endcase
         end
         dsp_pkg::ST_EMIT: begin
            if (ph_ff == dsp_pkg::PH_ADDR) begin
               ph_in = dsp_pkg::PH_DATA;
            end else begin
               ph_in = dsp_pkg::PH_ADDR;
               if (i_last) begin
                  state_in = dsp_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = dsp_pkg::ST_LOAD;
            ph_in    = dsp_pkg::PH_ADDR;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // memory controls
   // ------------------------------------------------------------------------
   always_comb begin
      edge_we    = accept && edge_ok;
      edge_waddr = total_ff[EAW-1:0];
      edge_wdata = {req_edge_from[VW-1:0], req_edge_to[VW-1:0], req_edge_weight};

      deg_we     = 1'b0;
      deg_waddr  = v_ff;
      deg_wdata  = '0;
      deg_raddr  = e_to;

      q_we       = 1'b0;
      q_waddr    = tail_ff[VW-1:0];
      q_wdata    = v_ff;

      dist_we    = 1'b0;
      dist_waddr = v_ff;
      dist_wdata = nd_ff;
      dist_raddr = i_ff[VW-1:0];

      unique case (state_ff)
         dsp_pkg::ST_CLR: begin
            deg_we     = 1'b1;
            deg_waddr  = i_ff[VW-1:0];
            dist_we    = 1'b1;
            dist_waddr = i_ff[VW-1:0];
            dist_wdata = (i_ff == '0) ? '0 : dsp_pkg::DIST_INF;
         end
         dsp_pkg::ST_DEG: begin
            deg_we    = (ph_ff == dsp_pkg::PH_WB);
            deg_wdata = IDW'(deg_rd + 1'b1);
         end
         dsp_pkg::ST_SEED: begin
            deg_raddr = i_ff[VW-1:0];
            q_we      = (ph_ff == dsp_pkg::PH_DATA) && (deg_rd == '0);
            q_wdata   = i_ff[VW-1:0];
         end
         dsp_pkg::ST_KSCAN: begin
            deg_we    = (ph_ff == dsp_pkg::PH_WB);
            deg_wdata = deg_dec;
            q_we      = (ph_ff == dsp_pkg::PH_WB) && push_ok;
         end
         dsp_pkg::ST_RHEAD: begin
            dist_raddr = q_rd;
         end
         dsp_pkg::ST_RSCAN: begin
            dist_raddr = e_to;
            dist_we    = (ph_ff == dsp_pkg::PH_WB) && (nd_ff < dist_rd);
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsp_pkg::ST_LOAD;
         ph_ff        <= dsp_pkg::PH_ADDR;
         vcount_ff    <= dsp_pkg::VCOUNT_RESET;
         total_ff     <= '0;
         drop_ff      <= 1'b0;
         k_ff         <= '0;
         i_ff         <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= (state_ff == dsp_pkg::ST_EMIT) && (ph_ff == dsp_pkg::PH_DATA);

         if (csr_valid && csr_ready) begin
            vcount_ff <= csr_vertex_count;
         end

         unique case (state_ff)
            dsp_pkg::ST_LOAD: begin
               if (accept) begin
                  if (edge_ok) begin
                     total_ff <= EW'(total_ff + 1'b1);
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  i_ff    <= '0;
                  k_ff    <= '0;
                  head_ff <= '0;
                  tail_ff <= '0;
               end
            end
            dsp_pkg::ST_CLR: begin
               i_ff <= i_last ? '0 : CW'(i_ff + 1'b1);
            end
            dsp_pkg::ST_DEG: begin
               if (ph_ff == dsp_pkg::PH_WB) begin
                  k_ff <= EW'(k_ff + 1'b1);
               end
            end
            dsp_pkg::ST_SEED: begin
               if (ph_ff == dsp_pkg::PH_DATA) begin
                  if (deg_rd == '0) begin
                     tail_ff <= CW'(tail_ff + 1'b1);
                  end
                  i_ff <= i_last ? '0 : CW'(i_ff + 1'b1);
               end
            end
            dsp_pkg::ST_KHEAD: begin
               if (ph_ff == dsp_pkg::PH_ADDR) begin
                  if (head_ff == tail_ff) begin
                     head_ff <= '0;
                  end
               end else begin
                  head_ff <= CW'(head_ff + 1'b1);
                  k_ff    <= '0;
               end
            end
            dsp_pkg::ST_KSCAN: begin
               if ((ph_ff == dsp_pkg::PH_DATA && !e_match) || ph_ff == dsp_pkg::PH_WB) begin
                  k_ff <= EW'(k_ff + 1'b1);
               end
               if (ph_ff == dsp_pkg::PH_WB && push_ok) begin
                  tail_ff <= CW'(tail_ff + 1'b1);
               end
            end
            dsp_pkg::ST_RHEAD: begin
               if (ph_ff == dsp_pkg::PH_ADDR && head_ff == tail_ff) begin
                  i_ff <= '0;
               end
               if (ph_ff == dsp_pkg::PH_WB) begin
                  head_ff <= CW'(head_ff + 1'b1);
                  k_ff    <= '0;
               end
            end
            dsp_pkg::ST_RSCAN: begin
               if ((ph_ff == dsp_pkg::PH_DATA && !e_match) || ph_ff == dsp_pkg::PH_WB) begin
                  k_ff <= EW'(k_ff + 1'b1);
               end
            end
            dsp_pkg::ST_EMIT: begin
               if (ph_ff == dsp_pkg::PH_DATA) begin
                  i_ff <= CW'(i_ff + 1'b1);
                  if (i_last) begin
                     total_ff <= '0;
                     drop_ff  <= 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // payload registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ph_ff == dsp_pkg::PH_DATA) begin
         v_ff <= e_to;
         nd_ff <= DW'(d_ff + DW'(e_wt));
      end
      if ((state_ff == dsp_pkg::ST_KHEAD || state_ff == dsp_pkg::ST_RHEAD)
          && ph_ff == dsp_pkg::PH_DATA) begin
         node_ff <= q_rd;
      end
      if (state_ff == dsp_pkg::ST_RHEAD && ph_ff == dsp_pkg::PH_WB) begin
         d_ff <= dist_rd;
      end
      if (state_ff == dsp_pkg::ST_EMIT && ph_ff == dsp_pkg::PH_DATA) begin
         rsp_index_ff <= dsp_pkg::VTX_W'(i_ff);
         rsp_dist_ff  <= dist_rd;
         rsp_last_ff  <= i_last;
         rsp_drop_ff  <= drop_ff;
      end
   end

   // ------------------------------------------------------------------------
   // memories
   // ------------------------------------------------------------------------
   dsp_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_addr (k_ff[EAW-1:0]),
      .rd_data (edge_rd)
   );

   dsp_ram #(.WIDTH(IDW), .DEPTH(MAX_VERTICES)) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_we),
      .wr_addr (deg_waddr),
      .wr_data (deg_wdata),
      .rd_addr (deg_raddr),
      .rd_data (deg_rd)
   );

   dsp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_ff[VW-1:0]),
      .rd_data (q_rd)
   );

   dsp_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (dist_raddr),
      .rd_data (dist_rd)
   );

   // ------------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------------
   assign busy              = (state_ff != dsp_pkg::ST_LOAD);
   assign csr_ready         = !busy;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_index  = rsp_index_ff;
   assign rsp_distance      = rsp_dist_ff;
   assign rsp_last_result   = rsp_last_ff;
   assign rsp_input_dropped = rsp_drop_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_last_beat_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> !busy)
      else $error("busy still high after final result beat");

   a_last_edge_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_edge |=> busy)
      else $error("solve did not start after last edge");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= MAXV_Q && head_ff <= tail_ff)
      else $error("order queue pointers out of range");

   a_edge_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= MAXE_C)
      else $error("edge count beyond capacity");

endmodule

`default_nettype wire
